// ----- design/vdc_pkg.sv -----
// Shared constants and controller-to-datapath command type for the vertex dedup cache.
package vdc_pkg;

  // Cache geometry and index width
  localparam int CACHE_ENTRIES = 32;
  localparam int INDEX_BITS    = 24;
  localparam int SLOT_BITS     = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

  // Field widths
  localparam int ID_BITS   = 31;
  localparam int WORD_BITS = 32;
  localparam int ATTR_BITS = 6 * WORD_BITS;
  localparam int MEM_BITS  = ATTR_BITS + INDEX_BITS;

  // One command per datapath phase
  typedef struct packed {
    logic capture;  // latch the corner, clear on mesh start
    logic match;    // compare ids against every entry
    logic pick;     // encode first hit, read its entry
    logic decide;   // compare attributes, allocate, write back, emit
  } cmd_t;

endpackage

// ----- design/vertex_dedup_cache.sv -----
// Top level of the vertex dedup cache: sequencer plus datapath.
//
//  channel | ports                               | handshake
//  --------+-------------------------------------+-------------------------------
//  input   | in_mesh_start .. in_uv_v            | accepted when start && !busy
//  result  | out_buffer_index, out_emit_new,     | out_valid high one cycle,
//          | out_overflow                        | taken at that cycle's end
//
// A corner passes match, pick and decide before the result strobe: id match
// into a hit vector, priority encode with a registered attribute memory read,
// then attribute compare and write back. busy drops in the cycle the result shows,
// so no new corner is taken before the result shows. Reset clears the valid bits,
// pointer and counter; no clearing pass. The receiver cannot stall.
module vertex_dedup_cache (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_mesh_start,
  input  logic [vdc_pkg::ID_BITS-1:0]      in_source_vertex_id,
  input  logic [vdc_pkg::WORD_BITS-1:0]    in_normal_x,
  input  logic [vdc_pkg::WORD_BITS-1:0]    in_normal_y,
  input  logic [vdc_pkg::WORD_BITS-1:0]    in_normal_z,
  input  logic [vdc_pkg::WORD_BITS-1:0]    in_color_rgba,
  input  logic [vdc_pkg::WORD_BITS-1:0]    in_uv_u,
  input  logic [vdc_pkg::WORD_BITS-1:0]    in_uv_v,
  output logic                             out_valid,
  output logic [vdc_pkg::INDEX_BITS-1:0]   out_buffer_index,
  output logic                             out_emit_new,
  output logic                             out_overflow
);

  vdc_pkg::cmd_t cmd;

  // Sequencer
  vdc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Datapath
  vdc_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_mesh_start       (in_mesh_start),
    .in_source_vertex_id (in_source_vertex_id),
    .in_normal_x         (in_normal_x),
    .in_normal_y         (in_normal_y),
    .in_normal_z         (in_normal_z),
    .in_color_rgba       (in_color_rgba),
    .in_uv_u             (in_uv_u),
    .in_uv_v             (in_uv_v),
    .out_valid           (out_valid),
    .out_buffer_index    (out_buffer_index),
    .out_emit_new        (out_emit_new),
    .out_overflow        (out_overflow)
  );

  // Every accepted transaction yields a result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("result strobe missing after accepted transaction");
  // Result strobe is a single-cycle pulse
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
  // Overflow result carries the saturated index and no allocation
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> (!out_emit_new && (out_buffer_index == '1)))
    else $error("overflow result malformed");

endmodule

// ----- design/vdc_ctrl.sv -----
// Sequencer for one corner lookup: capture, id match, entry read, decide.
module vdc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  output vdc_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_MATCH  = 4'b0010,
    S_PICK   = 4'b0100,
    S_DECIDE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (start) state_nxt = S_MATCH;
      S_MATCH:  state_nxt = S_PICK;
      S_PICK:   state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Commands and handshake
  assign busy        = (state_r != S_IDLE);
  assign cmd.capture = (state_r == S_IDLE) && start;
  assign cmd.match   = (state_r == S_MATCH);
  assign cmd.pick    = (state_r == S_PICK);
  assign cmd.decide  = (state_r == S_DECIDE);

  // Each accepted corner walks the phases in order
  a_match_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.match)
    else $error("match phase did not follow capture");
  a_decide_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.match |=> ##1 cmd.decide)
    else $error("decide phase did not follow match by two cycles");
  a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.match, cmd.pick, cmd.decide}))
    else $error("more than one phase commanded");

endmodule

// ----- design/vdc_datapath.sv -----
// Cache tags, valid bits, attribute memory, index counter and result register.
module vdc_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  vdc_pkg::cmd_t                    cmd,
  input  logic                             in_mesh_start,
  input  logic [vdc_pkg::ID_BITS-1:0]      in_source_vertex_id,
  input  logic [vdc_pkg::WORD_BITS-1:0]    in_normal_x,
  input  logic [vdc_pkg::WORD_BITS-1:0]    in_normal_y,
  input  logic [vdc_pkg::WORD_BITS-1:0]    in_normal_z,
  input  logic [vdc_pkg::WORD_BITS-1:0]    in_color_rgba,
  input  logic [vdc_pkg::WORD_BITS-1:0]    in_uv_u,
  input  logic [vdc_pkg::WORD_BITS-1:0]    in_uv_v,
  output logic                             out_valid,
  output logic [vdc_pkg::INDEX_BITS-1:0]   out_buffer_index,
  output logic                             out_emit_new,
  output logic                             out_overflow
);

  localparam int N  = vdc_pkg::CACHE_ENTRIES;
  localparam int SB = vdc_pkg::SLOT_BITS;
  localparam int IB = vdc_pkg::INDEX_BITS;

  // Captured transaction
  logic [vdc_pkg::ID_BITS-1:0]   id_r;
  logic [vdc_pkg::ATTR_BITS-1:0] attr_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      id_r   <= in_source_vertex_id;
      attr_r <= {in_uv_v, in_uv_u, in_color_rgba, in_normal_z, in_normal_y, in_normal_x};
    end
  end

  // Cache state
  logic [N-1:0]                  valid_r;
  logic [vdc_pkg::ID_BITS-1:0]   ids_r [N];
  logic [vdc_pkg::MEM_BITS-1:0]  mem [N];
  logic [SB-1:0]                 ptr_r;
  logic [IB:0]                   next_idx_r;

  // Id match against every tag, registered
  logic [N-1:0] hit_vec_r, hit_vec_nxt;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      hit_vec_nxt[i] = valid_r[i] && (ids_r[i] == id_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.match) hit_vec_r <= hit_vec_nxt;
  end

  // Lowest matching entry wins
  logic [SB-1:0] pick_slot;
  logic          pick_hit;

  always_comb begin
    pick_slot = '0;
    pick_hit  = 1'b0;
    for (int i = N - 1; i >= 0; i--) begin
      if (hit_vec_r[i]) begin
        pick_slot = SB'(i);
        pick_hit  = 1'b1;
      end
    end
  end

  logic [SB-1:0]                 found_r;
  logic                          hit_r;
  logic [vdc_pkg::MEM_BITS-1:0]  rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      found_r <= pick_slot;
      hit_r   <= pick_hit;
      rdata_r <= mem[pick_slot];
    end
  end

  // Decision
  logic                          same;
  logic                          exhausted;
  logic                          alloc;
  logic [SB-1:0]                 slot;
  logic [vdc_pkg::ATTR_BITS-1:0] rd_attr;
  logic [IB-1:0]                 rd_idx;

  assign rd_attr   = rdata_r[vdc_pkg::MEM_BITS-1:IB];
  assign rd_idx    = rdata_r[IB-1:0];
  assign same      = hit_r && (rd_attr == attr_r);
  assign exhausted = next_idx_r[IB];
  assign alloc     = cmd.decide && !same && !exhausted;
  assign slot      = hit_r ? found_r : ptr_r;

  // Attribute memory and tag write
  always_ff @(posedge clk) begin
    if (alloc) begin
      mem[slot]   <= {attr_r, next_idx_r[IB-1:0]};
      ids_r[slot] <= id_r;
    end
  end

  // Valid bits, replacement pointer, index counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      ptr_r      <= '0;
      next_idx_r <= '0;
    end else if (cmd.capture && in_mesh_start) begin
      valid_r    <= '0;
      ptr_r      <= '0;
      next_idx_r <= '0;
    end else if (alloc) begin
      valid_r[slot] <= 1'b1;
      next_idx_r    <= next_idx_r + (IB + 1)'(1);
      if (!hit_r) begin
        if (ptr_r == SB'(N - 1)) ptr_r <= '0;
        else                     ptr_r <= ptr_r + SB'(1);
      end
    end
  end

  // Result register
  logic valid_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_out_r <= 1'b0;
    else        valid_out_r <= cmd.decide;
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      if (same) begin
        out_buffer_index <= rd_idx;
        out_emit_new     <= 1'b0;
        out_overflow     <= 1'b0;
      end else if (exhausted) begin
        out_buffer_index <= '1;
        out_emit_new     <= 1'b0;
        out_overflow     <= 1'b1;
      end else begin
        out_buffer_index <= next_idx_r[IB-1:0];
        out_emit_new     <= 1'b1;
        out_overflow     <= 1'b0;
      end
    end
  end

  assign out_valid = valid_out_r;

  // Counter never passes its saturation value
  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    next_idx_r[IB] |-> (next_idx_r[IB-1:0] == '0))
    else $error("index counter ran past its limit");
  // An allocation bumps the counter by one
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    alloc |=> (next_idx_r == $past(next_idx_r) + (IB + 1)'(1)))
    else $error("index counter did not advance on allocation");
  // An allocated entry is valid afterwards
  a_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
    alloc |=> valid_r[$past(slot)])
    else $error("allocated entry not marked valid");

endmodule

// ----- tb/vdc_checker.sv -----
// Scoreboard for the vertex dedup cache: predicts each corner's result and checks the strobe.
`timescale 1ns / 1ps

module vdc_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             busy,
  input  logic                             in_mesh_start,
  input  logic [vdc_pkg::ID_BITS-1:0]      in_source_vertex_id,
  input  logic [vdc_pkg::WORD_BITS-1:0]    in_normal_x,
  input  logic [vdc_pkg::WORD_BITS-1:0]    in_normal_y,
  input  logic [vdc_pkg::WORD_BITS-1:0]    in_normal_z,
  input  logic [vdc_pkg::WORD_BITS-1:0]    in_color_rgba,
  input  logic [vdc_pkg::WORD_BITS-1:0]    in_uv_u,
  input  logic [vdc_pkg::WORD_BITS-1:0]    in_uv_v,
  input  logic                             out_valid,
  input  logic [vdc_pkg::INDEX_BITS-1:0]   out_buffer_index,
  input  logic                             out_emit_new,
  input  logic                             out_overflow,
  output int                               mismatches,
  output int                               outstanding
);

  typedef struct packed {
    logic [vdc_pkg::INDEX_BITS-1:0] index;
    logic                           emit_new;
    logic                           overflow;
  } dedup_result_t;

  // Shadow copy of the cache
  logic                           line_live  [vdc_pkg::CACHE_ENTRIES];
  logic [vdc_pkg::ID_BITS-1:0]    line_id    [vdc_pkg::CACHE_ENTRIES];
  logic [vdc_pkg::INDEX_BITS-1:0] line_index [vdc_pkg::CACHE_ENTRIES];
  logic [vdc_pkg::ATTR_BITS-1:0]  line_attr  [vdc_pkg::CACHE_ENTRIES];
  logic [vdc_pkg::SLOT_BITS-1:0]  victim_ptr;
  logic [vdc_pkg::INDEX_BITS:0]   alloc_count;

  dedup_result_t expected_q[$];

  function automatic void flush_cache();
    for (int k = 0; k < vdc_pkg::CACHE_ENTRIES; k++) begin
      line_live[k] = 1'b0;
    end
    victim_ptr  = '0;
    alloc_count = '0;
  endfunction

  // Look up one corner, update the shadow cache, return its result
  function automatic dedup_result_t dedup_corner(input logic mesh,
                                                 input logic [vdc_pkg::ID_BITS-1:0] id,
                                                 input logic [vdc_pkg::ATTR_BITS-1:0] attr);
    dedup_result_t res;
    int hit;
    int slot;
    hit = -1;
    if (mesh) flush_cache();
    for (int k = 0; k < vdc_pkg::CACHE_ENTRIES; k++) begin
      if (hit < 0 && line_live[k] && line_id[k] == id) hit = k;
    end
    // id present with identical attributes: reuse its index
    if (hit >= 0 && line_attr[hit] == attr) begin
      res.index    = line_index[hit];
      res.emit_new = 1'b0;
      res.overflow = 1'b0;
      return res;
    end
    // counter exhausted: saturate, leave the cache alone
    if (alloc_count[vdc_pkg::INDEX_BITS]) begin
      res.index    = '1;
      res.emit_new = 1'b0;
      res.overflow = 1'b1;
      return res;
    end
    if (hit >= 0) begin
      slot = hit;
    end else begin
      slot = victim_ptr;
      victim_ptr = (int'(victim_ptr) == vdc_pkg::CACHE_ENTRIES - 1) ? '0 : victim_ptr + 1'b1;
    end
    line_live[slot]  = 1'b1;
    line_id[slot]    = id;
    line_index[slot] = alloc_count[vdc_pkg::INDEX_BITS-1:0];
    line_attr[slot]  = attr;
    res.index    = alloc_count[vdc_pkg::INDEX_BITS-1:0];
    res.emit_new = 1'b1;
    res.overflow = 1'b0;
    alloc_count  = alloc_count + 1'b1;
    return res;
  endfunction

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Compare the result strobe first, then predict any corner taken at this edge
  always @(posedge clk) begin
    dedup_result_t want;
    if (!rst_n) begin
      flush_cache();
      expected_q.delete();
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result index %0h emit_new %0b overflow %0b", $time,
                   out_buffer_index, out_emit_new, out_overflow);
          mismatches = mismatches + 1;
        end else begin
          want = expected_q.pop_front();
          if (out_buffer_index !== want.index) begin
            $display("%0t: buffer_index expected %0h, got %0h", $time, want.index,
                     out_buffer_index);
            mismatches = mismatches + 1;
          end
          if (out_emit_new !== want.emit_new) begin
            $display("%0t: emit_new expected %0b, got %0b", $time, want.emit_new,
                     out_emit_new);
            mismatches = mismatches + 1;
          end
          if (out_overflow !== want.overflow) begin
            $display("%0t: overflow expected %0b, got %0b", $time, want.overflow,
                     out_overflow);
            mismatches = mismatches + 1;
          end
        end
      end
      if (start && !busy) begin
        expected_q.push_back(dedup_corner(in_mesh_start, in_source_vertex_id,
                                          {in_normal_x, in_normal_y, in_normal_z,
                                           in_color_rgba, in_uv_u, in_uv_v}));
      end
    end
    outstanding = expected_q.size();
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the vertex dedup cache testbench: clock, reset, corner stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int STALL_LIMIT  = 1000;
  localparam int PHASE_ITEMS  = 425;
  localparam int HISTORY      = 48;

  typedef struct packed {
    logic [vdc_pkg::ID_BITS-1:0]          id;
    logic [5:0][vdc_pkg::WORD_BITS-1:0]   attr;  // nx, ny, nz, color, u, v
  } corner_t;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             start;
  logic                             busy;
  logic                             in_mesh_start;
  logic [vdc_pkg::ID_BITS-1:0]      in_source_vertex_id;
  logic [vdc_pkg::WORD_BITS-1:0]    in_normal_x;
  logic [vdc_pkg::WORD_BITS-1:0]    in_normal_y;
  logic [vdc_pkg::WORD_BITS-1:0]    in_normal_z;
  logic [vdc_pkg::WORD_BITS-1:0]    in_color_rgba;
  logic [vdc_pkg::WORD_BITS-1:0]    in_uv_u;
  logic [vdc_pkg::WORD_BITS-1:0]    in_uv_v;
  logic                             out_valid;
  logic [vdc_pkg::INDEX_BITS-1:0]   out_buffer_index;
  logic                             out_emit_new;
  logic                             out_overflow;
  int                               mismatches;
  int                               outstanding;
  int                               quiet_cycles;

  corner_t recent [HISTORY];
  int      recent_n;
  int      recent_wr;

  vertex_dedup_cache DUT (.*);

  vdc_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: cycles with neither a corner nor a result transaction
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic corner_t fresh_corner();
    corner_t c;
    logic [31:0] raw;
    raw = $urandom();
    c.id = raw[vdc_pkg::ID_BITS-1:0];
    for (int w = 0; w < 6; w++) c.attr[w] = $urandom();
    return c;
  endfunction

  // Present one corner and hold it until taken; start stays high on return
  task automatic send_corner(input logic mesh, input corner_t c);
    start               <= 1'b1;
    in_mesh_start       <= mesh;
    in_source_vertex_id <= c.id;
    in_normal_x         <= c.attr[0];
    in_normal_y         <= c.attr[1];
    in_normal_z         <= c.attr[2];
    in_color_rgba       <= c.attr[3];
    in_uv_u             <= c.attr[4];
    in_uv_v             <= c.attr[5];
    do @(posedge clk); while (busy);
    recent[recent_wr] = c;
    recent_wr = (recent_wr + 1) % HISTORY;
    if (recent_n < HISTORY) recent_n++;
  endtask

  // Drop start for a random idle gap, with junk on the payload
  task automatic idle_gap();
    corner_t junk;
    junk = fresh_corner();
    start               <= 1'b0;
    in_mesh_start       <= junk.id[0];
    in_source_vertex_id <= junk.id;
    in_normal_x         <= junk.attr[0];
    in_normal_y         <= junk.attr[1];
    in_normal_z         <= junk.attr[2];
    in_color_rgba       <= junk.attr[3];
    in_uv_u             <= junk.attr[4];
    in_uv_v             <= junk.attr[5];
    repeat ($urandom_range(1, 8)) @(posedge clk);
  endtask

  function automatic corner_t pick_recent();
    return recent[(recent_wr + HISTORY - 1 - $urandom_range(recent_n - 1)) % HISTORY];
  endfunction

  initial begin
    corner_t c;
    corner_t base;
    int      pick;
    int      idle_pct [4];

    idle_pct            = '{0, 82, 0, 18};
    rst_n               = 1'b0;
    start               = 1'b0;
    in_mesh_start       = 1'b0;
    in_source_vertex_id = '0;
    in_normal_x         = '0;
    in_normal_y         = '0;
    in_normal_z         = '0;
    in_color_rgba       = '0;
    in_uv_u             = '0;
    in_uv_v             = '0;
    recent_n            = 0;
    recent_wr           = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero and all-ones corners, hits, in-place updates, mesh restart
    c.id = '0;
    c.attr = '0;
    send_corner(1'b1, c);
    send_corner(1'b0, c);
    base.id = '1;
    base.attr = '1;
    send_corner(1'b0, base);
    send_corner(1'b0, base);
    c.attr[0][31] = 1'b1;
    send_corner(1'b0, c);
    c.attr = '0;
    send_corner(1'b0, c);
    send_corner(1'b0, c);
    for (int w = 0; w < 6; w++) begin
      c = base;
      c.attr[w] = '0;
      send_corner(1'b0, c);
    end
    send_corner(1'b0, c);
    send_corner(1'b0, base);
    // restart with a corner that was cached: must miss and get index zero
    send_corner(1'b1, base);
    send_corner(1'b1, base);
    send_corner(1'b0, base);

    // Random: mostly repeated corners with random content, some noise
    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < idle_pct[ph]) idle_gap();
        pick = $urandom_range(99);
        if (recent_n == 0 || pick >= 85) begin
          c = fresh_corner();
        end else if (pick < 50) begin
          c = pick_recent();
        end else if (pick < 70) begin
          // same id, changed attributes
          c = pick_recent();
          c.attr[$urandom_range(5)] ^= 32'h1 << $urandom_range(31);
          if ($urandom_range(1)) c.attr[$urandom_range(5)] = $urandom();
        end else begin
          // neighbor id, same attributes
          c = pick_recent();
          c.id ^= 31'h1 << $urandom_range(vdc_pkg::ID_BITS - 1);
        end
        send_corner(($urandom_range(99) < 3), c);
      end
    end

    // Drain
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- vertex_dedup_cache.f -----
design/vdc_pkg.sv
design/vdc_ctrl.sv
design/vdc_datapath.sv
design/vertex_dedup_cache.sv
tb/vdc_checker.sv
tb/testbench.sv
